[rtl/core/trl_pkg.sv]
// ----------------------------------------------------------------------------
// trl_pkg
// Shared widths, register indexes and transaction types of the 2D
// trilateration solver.
// ----------------------------------------------------------------------------
package trl_pkg;

  localparam int COORD_W = 16;               // anchor coordinate, signed Q7.8
  localparam int RANGE_W = 16;               // measured distance, unsigned Q8.8
  localparam int OUT_W   = 24;               // position, signed Q15.8
  localparam int SQ_W    = 2 * COORD_W;      // square or sum of two squares
  localparam int A_W     = COORD_W + 2;      // matrix entry 2*(xi - x2)
  localparam int B_W     = SQ_W + 3;         // right-hand side entry
  localparam int PD_W    = 2 * A_W;          // determinant partial product
  localparam int DET_W   = PD_W + 1;         // determinant
  localparam int PN_W    = A_W + B_W;        // numerator partial product
  localparam int NUM_W   = PN_W + 1;         // numerator
  localparam int DIV_W   = DET_W + OUT_W;    // divider compare width
  localparam int FRONT_LAT = 4;
  localparam int DIV_LAT   = OUT_W + 1;
  localparam int LATENCY   = FRONT_LAT + DIV_LAT;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_A0X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A0Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A1X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_A2Y = 3'd5;

  localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] POS_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
  } anchors_t;

  // One quotient to be formed: magnitudes, result sign and a flag that the
  // quotient is already known to exceed the output range.
  typedef struct packed {
    logic             neg;
    logic             big;
    logic [NUM_W-1:0] num;
    logic [DET_W-1:0] den;
  } quo_req_t;

  typedef struct packed {
    logic             valid;
    logic             sing;
    quo_req_t         qx;
    quo_req_t         qy;
  } front_t;

  typedef struct packed {
    logic             sat;
    logic [OUT_W-1:0] val;
  } quo_res_t;

  function automatic logic [SQ_W-1:0] sq_coord(input logic signed [COORD_W-1:0] v);
    logic signed [SQ_W-1:0] p;
    p = SQ_W'(v) * SQ_W'(v);
    return p;
  endfunction

endpackage

[rtl/core/trl_front.sv]
// ----------------------------------------------------------------------------
// trl_front
// Four pipeline stages that build the linear system and the Cramer
// numerators and determinant, then split them into sign and magnitude.
// ----------------------------------------------------------------------------
module trl_front
  import trl_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [trl_pkg::RANGE_W-1:0] in_range0,
  input  logic [trl_pkg::RANGE_W-1:0] in_range1,
  input  logic [trl_pkg::RANGE_W-1:0] in_range2,
  input  trl_pkg::anchors_t           anchors,
  output trl_pkg::front_t             front
);

  // Stage 1: matrix entries and all squares.
  logic                      v1_r;
  logic signed [A_W-1:0]     a00_r, a01_r, a10_r, a11_r;
  logic [SQ_W-1:0]           rs0_r, rs1_r, rs2_r, s0_r, s1_r, s2_r;
  logic signed [COORD_W:0]   d00, d01, d10, d11;

  always_comb begin
    d00 = {anchors.x0[COORD_W-1], anchors.x0} - {anchors.x2[COORD_W-1], anchors.x2};
    d01 = {anchors.y0[COORD_W-1], anchors.y0} - {anchors.y2[COORD_W-1], anchors.y2};
    d10 = {anchors.x1[COORD_W-1], anchors.x1} - {anchors.x2[COORD_W-1], anchors.x2};
    d11 = {anchors.y1[COORD_W-1], anchors.y1} - {anchors.y2[COORD_W-1], anchors.y2};
  end

  always_ff @(posedge clk) begin
    a00_r <= {d00, 1'b0};
    a01_r <= {d01, 1'b0};
    a10_r <= {d10, 1'b0};
    a11_r <= {d11, 1'b0};
    rs0_r <= SQ_W'(in_range0) * SQ_W'(in_range0);
    rs1_r <= SQ_W'(in_range1) * SQ_W'(in_range1);
    rs2_r <= SQ_W'(in_range2) * SQ_W'(in_range2);
    s0_r  <= sq_coord(anchors.x0) + sq_coord(anchors.y0);
    s1_r  <= sq_coord(anchors.x1) + sq_coord(anchors.y1);
    s2_r  <= sq_coord(anchors.x2) + sq_coord(anchors.y2);
  end

  // Stage 2: right-hand side and determinant partial products.
  logic                      v2_r;
  logic signed [A_W-1:0]     a00b_r, a01b_r, a10b_r, a11b_r;
  logic signed [B_W-1:0]     b0_r, b1_r;
  logic signed [PD_W-1:0]    pd0_r, pd1_r;
  logic signed [B_W-1:0]     refb;

  assign refb = $signed(B_W'(rs2_r)) - $signed(B_W'(s2_r));

  always_ff @(posedge clk) begin
    a00b_r <= a00_r;
    a01b_r <= a01_r;
    a10b_r <= a10_r;
    a11b_r <= a11_r;
    b0_r   <= refb + $signed(B_W'(s0_r)) - $signed(B_W'(rs0_r));
    b1_r   <= refb + $signed(B_W'(s1_r)) - $signed(B_W'(rs1_r));
    pd0_r  <= PD_W'(a00_r) * PD_W'(a11_r);
    pd1_r  <= PD_W'(a01_r) * PD_W'(a10_r);
  end

  // Stage 3: determinant and numerator partial products.
  logic                      v3_r;
  logic signed [DET_W-1:0]   det_r;
  logic signed [PN_W-1:0]    pnx0_r, pnx1_r, pny0_r, pny1_r;

  always_ff @(posedge clk) begin
    det_r  <= DET_W'(pd0_r) - DET_W'(pd1_r);
    pnx0_r <= PN_W'(a11b_r) * PN_W'(b0_r);
    pnx1_r <= PN_W'(a01b_r) * PN_W'(b1_r);
    pny0_r <= PN_W'(a00b_r) * PN_W'(b1_r);
    pny1_r <= PN_W'(a10b_r) * PN_W'(b0_r);
  end

  // Stage 4: numerators, magnitudes and signs.
  logic signed [NUM_W-1:0]   numx, numy;
  logic [NUM_W-1:0]          magx, magy;
  logic [DET_W-1:0]          magd;
  logic [DIV_W-1:0]          lim;
  front_t                    front_nxt, front_r;

  always_comb begin
    numx = NUM_W'(pnx0_r) - NUM_W'(pnx1_r);
    numy = NUM_W'(pny0_r) - NUM_W'(pny1_r);
    magx = numx[NUM_W-1] ? NUM_W'(-numx) : NUM_W'(numx);
    magy = numy[NUM_W-1] ? NUM_W'(-numy) : NUM_W'(numy);
    magd = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    lim  = {magd, {OUT_W{1'b0}}};
    front_nxt.valid  = v3_r;
    front_nxt.sing   = (det_r == '0);
    front_nxt.qx.neg = numx[NUM_W-1] ^ det_r[DET_W-1];
    front_nxt.qx.big = DIV_W'(magx) >= lim;
    front_nxt.qx.num = magx;
    front_nxt.qx.den = magd;
    front_nxt.qy.neg = numy[NUM_W-1] ^ det_r[DET_W-1];
    front_nxt.qy.big = DIV_W'(magy) >= lim;
    front_nxt.qy.num = magy;
    front_nxt.qy.den = magd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      front_r <= '0;
    end else begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

endmodule

[rtl/core/trl_divider.sv]
// ----------------------------------------------------------------------------
// trl_divider
// Pipelined restoring divider, one quotient bit per stage, followed by a
// sign and saturation stage.
// ----------------------------------------------------------------------------
module trl_divider
  import trl_pkg::*;
(
  input  logic               clk,
  input  trl_pkg::quo_req_t  req,
  output trl_pkg::quo_res_t  res
);

  logic [NUM_W-1:0] rem_r [0:OUT_W-1];
  logic [DET_W-1:0] den_r [0:OUT_W-1];
  logic [OUT_W-1:0] q_r   [0:OUT_W-1];
  logic             neg_r [0:OUT_W-1];
  logic             big_r [0:OUT_W-1];

  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DET_W-1:0] den_in;
    logic [OUT_W-1:0] q_in;
    logic             neg_in, big_in;
    logic [DIV_W-1:0] shifted;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in = req.num;
      assign den_in = req.den;
      assign q_in   = '0;
      assign neg_in = req.neg;
      assign big_in = req.big;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
      assign neg_in = neg_r[s-1];
      assign big_in = big_r[s-1];
    end

    assign shifted = DIV_W'(den_in) << (OUT_W - 1 - s);
    assign take    = DIV_W'(rem_in) >= shifted;

    always_ff @(posedge clk) begin
      rem_r[s] <= take ? NUM_W'(DIV_W'(rem_in) - shifted) : rem_in;
      q_r[s]   <= q_in | (OUT_W'(take) << (OUT_W - 1 - s));
      den_r[s] <= den_in;
      neg_r[s] <= neg_in;
      big_r[s] <= big_in;
    end
  end

  logic [OUT_W-1:0] q, lim;
  quo_res_t         res_nxt, res_r;

  always_comb begin
    q   = q_r[OUT_W-1];
    lim = neg_r[OUT_W-1] ? POS_MIN : POS_MAX;
    res_nxt.sat = big_r[OUT_W-1] || (q > lim);
    if (res_nxt.sat) begin
      res_nxt.val = neg_r[OUT_W-1] ? POS_MIN : POS_MAX;
    end else begin
      res_nxt.val = neg_r[OUT_W-1] ? OUT_W'(-q) : q;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

[rtl/core/trilateration_2d_three_anchor.sv]
// ----------------------------------------------------------------------------
// trilateration_2d_three_anchor
// Solves the tag position from three anchor distances by Cramer's rule.
// ----------------------------------------------------------------------------
// A transaction is accepted on every clock edge where start is high; busy is
// always low, so a new set of three ranges may be issued in every cycle. Each
// transaction produces exactly one result, shown on the out_ ports for one
// cycle with out_valid high. The front stages build the system, the determinant
// and the numerators, the divider stages form one quotient bit each in the
// pipelined dividers, and a last stage applies sign and saturation.
// The receiver cannot stall the result. Anchor positions are written through
// the cfg_ port and must only be changed while no transaction is in flight.
// ----------------------------------------------------------------------------
module trilateration_2d_three_anchor
  import trl_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [trl_pkg::RANGE_W-1:0]   in_range0,
  input  logic [trl_pkg::RANGE_W-1:0]   in_range1,
  input  logic [trl_pkg::RANGE_W-1:0]   in_range2,
  input  logic                          cfg_we,
  input  logic [trl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trl_pkg::COORD_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  output logic signed [trl_pkg::OUT_W-1:0] out_pos_x,
  output logic signed [trl_pkg::OUT_W-1:0] out_pos_y,
  output logic                          out_singular,
  output logic                          out_overflow
);

  // The pipeline never holds off, so an item can enter on every edge.
  assign busy = 1'b0;

  // Anchor registers; anchor 2 is the reference of both rows.
  anchors_t anc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anc_r.x0 <= COORD_W'(0);
      anc_r.y0 <= COORD_W'(0);
      anc_r.x1 <= COORD_W'(0);
      anc_r.y1 <= COORD_W'(230);
      anc_r.x2 <= COORD_W'(410);
      anc_r.y2 <= COORD_W'(0);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_A0X: anc_r.x0 <= cfg_wdata;
        CFG_A0Y: anc_r.y0 <= cfg_wdata;
        CFG_A1X: anc_r.x1 <= cfg_wdata;
        CFG_A1Y: anc_r.y1 <= cfg_wdata;
        CFG_A2X: anc_r.x2 <= cfg_wdata;
        CFG_A2Y: anc_r.y2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  front_t   front;
  quo_res_t res_x, res_y;

  trl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_range0(in_range0),
    .in_range1(in_range1),
    .in_range2(in_range2),
    .anchors  (anc_r),
    .front    (front)
  );

  trl_divider u_div_x (.clk(clk), .req(front.qx), .res(res_x));
  trl_divider u_div_y (.clk(clk), .req(front.qy), .res(res_y));

  // Valid and singular flags ride alongside the dividers with equal latency.
  logic [DIV_LAT-1:0] vld_r, sing_r;

  always_ff @(posedge clk) begin
    sing_r <= {sing_r[DIV_LAT-2:0], front.sing};
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_LAT-2:0], front.valid};
    end
  end

  // A singular system forces a zero position and no overflow.
  assign out_valid    = vld_r[DIV_LAT-1];
  assign out_singular = sing_r[DIV_LAT-1];
  assign out_pos_x    = out_singular ? '0 : res_x.val;
  assign out_pos_y    = out_singular ? '0 : res_y.val;
  assign out_overflow = !out_singular && (res_x.sat || res_y.sat);

  // Every accepted transaction yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("result missing after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##LATENCY !out_valid)
    else $error("result without a transaction");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_pos_x == POS_MAX || out_pos_x == POS_MIN ||
       out_pos_y == POS_MAX || out_pos_y == POS_MIN))
    else $error("overflow flagged without a saturated coordinate");

endmodule
